/* sv/bmprle_pkg.sv */
// Shared types and constants of the BMP RLE4/RLE8 palette decoder.
`default_nettype none

package bmprle_pkg;

  // Largest row width; wider image_width settings are clamped to it.
  localparam logic [16:0] MaxWidth = 17'd65536;
  localparam int unsigned PaletteDepthDefault = 256;

  localparam logic [1:0] KindPalette = 2'd0;
  localparam logic [1:0] KindStart   = 2'd1;
  localparam logic [1:0] KindData    = 2'd2;

  localparam logic [1:0] CfgImageWidth  = 2'd0;
  localparam logic [1:0] CfgImageHeight = 2'd1;
  localparam logic [1:0] CfgBitsPerIdx  = 2'd2;
  localparam logic [1:0] CfgDataSize    = 2'd3;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StOddSize  = 3'd1;
  localparam logic [2:0] StEarlyEnd = 3'd2;
  localparam logic [2:0] StDelta    = 3'd3;
  localparam logic [2:0] StOverflow = 3'd4;

  // Escape codes: second byte of a pair whose first byte is zero.
  localparam logic [7:0] EscEndOfLine  = 8'd0;
  localparam logic [7:0] EscEndOfImage = 8'd1;
  localparam logic [7:0] EscDelta      = 8'd2;

  // Run descriptor without colours; colours come from the palette memory.
  typedef struct packed {
    logic [15:0] row;
    logic [16:0] start_column;
    logic [16:0] run_length;
    logic        line_end;
    logic        image_end;
    logic [2:0]  status;
  } run_t;

  typedef struct packed {
    run_t        run;
    logic [31:0] first_colour;
    logic [31:0] second_colour;
  } result_t;

endpackage

`default_nettype wire

/* sv/bmprle_pal_mem.sv */
// Palette memory: one write port, two registered read ports, reset via valid bits.
`default_nettype none

module bmprle_pal_mem #(
  parameter int unsigned PaletteDepth = bmprle_pkg::PaletteDepthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        we_i,
  input  wire logic [7:0]  waddr_i,
  input  wire logic [31:0] wdata_i,
  input  wire logic        re_i,
  input  wire logic [7:0]  raddr_a_i,
  input  wire logic [7:0]  raddr_b_i,
  output logic      [31:0] rdata_a_o,
  output logic      [31:0] rdata_b_o
);

  localparam int unsigned AddrW = (PaletteDepth > 1) ? $clog2(PaletteDepth) : 1;
  localparam logic [8:0] DepthC = 9'(PaletteDepth);

  logic [31:0] mem [PaletteDepth];
  logic [PaletteDepth-1:0] vld_q;
  logic [31:0] rd_a_q, rd_b_q;
  logic ok_a_q, ok_b_q;
  logic w_in, a_in, b_in;

  assign w_in = {1'b0, waddr_i} < DepthC;
  assign a_in = {1'b0, raddr_a_i} < DepthC;
  assign b_in = {1'b0, raddr_b_i} < DepthC;

  always_ff @(posedge clk_i) begin
    if (we_i && w_in) begin
      mem[waddr_i[AddrW-1:0]] <= wdata_i;
    end
    if (re_i) begin
      rd_a_q <= mem[raddr_a_i[AddrW-1:0]];
      rd_b_q <= mem[raddr_b_i[AddrW-1:0]];
    end
  end

  // Entries never written since reset read as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      ok_a_q <= 1'b0;
      ok_b_q <= 1'b0;
    end else begin
      if (we_i && w_in) begin
        vld_q[waddr_i[AddrW-1:0]] <= 1'b1;
      end
      if (re_i) begin
        ok_a_q <= a_in && vld_q[raddr_a_i[AddrW-1:0]];
        ok_b_q <= b_in && vld_q[raddr_b_i[AddrW-1:0]];
      end
    end
  end

  assign rdata_a_o = ok_a_q ? rd_a_q : 32'd0;
  assign rdata_b_o = ok_b_q ? rd_b_q : 32'd0;

endmodule

`default_nettype wire

/* sv/bmprle_ctrl.sv */
// Stream decoder: configuration registers, position and phase state, run decisions.
`default_nettype none

module bmprle_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [1:0]            cfg_idx_i,
  input  wire logic [30:0]           cfg_wdata_i,
  input  wire logic                  accept_i,
  input  wire logic [1:0]            kind_i,
  input  wire logic [7:0]            data_byte_i,
  output logic                       emit_o,
  output logic                       cen_o,
  output bmprle_pkg::run_t           run_o,
  output logic [7:0]                 raddr_a_o,
  output logic [7:0]                 raddr_b_o
);

  typedef enum logic [3:0] {
    PhFirst  = 4'b0001,
    PhSecond = 4'b0010,
    PhAbs    = 4'b0100,
    PhPad    = 4'b1000
  } phase_e;

  logic [16:0] width_q, height_q;
  logic [3:0]  bpi_q;
  logic [30:0] size_q;

  phase_e      phase_q, phase_d;
  logic [15:0] row_q, row_d;
  logic [16:0] col_q, col_d;
  logic [7:0]  first_q, first_d;
  logic [7:0]  abs_left_q, abs_left_d;
  logic [7:0]  abs_tot_q, abs_tot_d;
  logic [30:0] cons_q, cons_d;
  logic        err_q, err_d;

  logic        rle4;
  logic [16:0] eff_w, left, hm1, run_len;
  logic [8:0]  need;
  logic [30:0] cons_inc, avail;
  logic        abs_over;
  logic [7:0]  abs_step, abs_len, abs_rem;
  logic [8:0]  tot_p1;
  logic        pad;
  logic [7:0]  b;

  assign b        = data_byte_i;
  assign rle4     = bpi_q == 4'd4;
  assign eff_w    = (width_q > bmprle_pkg::MaxWidth) ? bmprle_pkg::MaxWidth : width_q;
  assign left     = (col_q < eff_w) ? (eff_w - col_q) : 17'd0;
  assign hm1      = height_q - 17'd1;
  assign run_len  = ({9'd0, first_q} > left) ? left : {9'd0, first_q};
  assign need     = rle4 ? (({1'b0, b} + 9'd1) >> 1) : {1'b0, b};
  assign cons_inc = cons_q + 31'd1;
  assign avail    = size_q - cons_inc;
  assign abs_over = (({1'b0, col_q} + {10'd0, b}) > {1'b0, eff_w})
                 || ({22'd0, need} > avail);
  assign abs_step = (rle4 && abs_left_q >= 8'd2) ? 8'd2 : 8'd1;
  assign abs_len  = (abs_step > abs_left_q) ? abs_left_q : abs_step;
  assign abs_rem  = abs_left_q - abs_len;
  assign tot_p1   = {1'b0, abs_tot_q} + 9'd1;
  assign pad      = rle4 ? tot_p1[1] : abs_tot_q[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 17'd1;
      height_q <= 17'd1;
      bpi_q    <= 4'd8;
      size_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bmprle_pkg::CfgImageWidth:  width_q  <= cfg_wdata_i[16:0];
        bmprle_pkg::CfgImageHeight: height_q <= cfg_wdata_i[16:0];
        bmprle_pkg::CfgBitsPerIdx:  bpi_q    <= cfg_wdata_i[3:0];
        bmprle_pkg::CfgDataSize:    size_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_d    = phase_q;
    row_d      = row_q;
    col_d      = col_q;
    first_d    = first_q;
    abs_left_d = abs_left_q;
    abs_tot_d  = abs_tot_q;
    cons_d     = cons_q;
    err_d      = err_q;
    emit_o     = 1'b0;
    cen_o      = 1'b0;
    raddr_a_o  = b;
    raddr_b_o  = b;
    run_o              = '0;
    run_o.row          = row_q;
    run_o.start_column = col_q;
    run_o.status       = bmprle_pkg::StOk;

    if (accept_i) begin
      unique case (kind_i)
        bmprle_pkg::KindStart: begin
          row_d      = hm1[15:0];
          col_d      = '0;
          first_d    = '0;
          phase_d    = PhFirst;
          abs_left_d = '0;
          abs_tot_d  = '0;
          cons_d     = '0;
          err_d      = size_q[0];
          if (size_q[0]) begin
            emit_o             = 1'b1;
            run_o.row          = hm1[15:0];
            run_o.start_column = '0;
            run_o.status       = bmprle_pkg::StOddSize;
          end
        end
        bmprle_pkg::KindData: begin
          if (!err_q && cons_q < size_q) begin
            cons_d = cons_inc;
            unique case (phase_q)
              PhFirst: begin
                first_d = b;
                phase_d = PhSecond;
              end
              PhSecond: begin
                phase_d = PhFirst;
                if (first_q != 8'd0) begin
                  emit_o           = 1'b1;
                  cen_o            = 1'b1;
                  run_o.run_length = run_len;
                  raddr_a_o        = rle4 ? {4'd0, b[7:4]} : b;
                  raddr_b_o        = rle4 ? {4'd0, b[3:0]} : b;
                  col_d            = col_q + run_len;
                end else if (b == bmprle_pkg::EscEndOfLine) begin
                  // end of line: fill with entry 0, step one row up the file
                  emit_o           = 1'b1;
                  cen_o            = 1'b1;
                  run_o.run_length = left;
                  run_o.line_end   = 1'b1;
                  raddr_a_o        = 8'd0;
                  raddr_b_o        = 8'd0;
                  col_d            = '0;
                  row_d            = row_q - 16'd1;
                end else if (b == bmprle_pkg::EscEndOfImage) begin
                  emit_o = 1'b1;
                  if (row_q != 16'd0 && col_q != hm1) begin
                    run_o.status = bmprle_pkg::StEarlyEnd;
                    err_d        = 1'b1;
                  end else begin
                    run_o.image_end = 1'b1;
                  end
                end else if (b == bmprle_pkg::EscDelta) begin
                  emit_o       = 1'b1;
                  run_o.status = bmprle_pkg::StDelta;
                  err_d        = 1'b1;
                end else if (abs_over) begin
                  emit_o       = 1'b1;
                  run_o.status = bmprle_pkg::StOverflow;
                  err_d        = 1'b1;
                end else begin
                  abs_left_d = b;
                  abs_tot_d  = b;
                  phase_d    = PhAbs;
                end
              end
              PhAbs: begin
                emit_o           = 1'b1;
                cen_o            = 1'b1;
                run_o.run_length = {9'd0, abs_len};
                raddr_a_o        = rle4 ? {4'd0, b[7:4]} : b;
                raddr_b_o        = (rle4 && abs_left_q >= 8'd2) ? {4'd0, b[3:0]} : raddr_a_o;
                col_d            = col_q + {9'd0, abs_len};
                abs_left_d       = abs_rem;
                if (abs_rem == 8'd0) begin
                  phase_d = pad ? PhPad : PhFirst;
                end
              end
              default: phase_d = PhFirst;  // drop the pad byte
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhFirst;
      row_q      <= '0;
      col_q      <= '0;
      first_q    <= '0;
      abs_left_q <= '0;
      abs_tot_q  <= '0;
      cons_q     <= '0;
      err_q      <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      row_q      <= row_d;
      col_q      <= col_d;
      first_q    <= first_d;
      abs_left_q <= abs_left_d;
      abs_tot_q  <= abs_tot_d;
      cons_q     <= cons_d;
      err_q      <= err_d;
    end
  end

endmodule

`default_nettype wire

/* sv/bmprle_out.sv */
// Output stage: result register aligned with the palette read, plus a skid register.
`default_nettype none

module bmprle_out (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                load_i,
  input  wire logic                cen_i,
  input  wire bmprle_pkg::run_t    run_i,
  input  wire logic [31:0]         rdata_a_i,
  input  wire logic [31:0]         rdata_b_i,
  input  wire logic                out_stall_i,
  output logic                     out_valid_o,
  output logic                     in_stall_o,
  output bmprle_pkg::result_t      res_o
);

  logic                s_v_q, skid_v_q;
  bmprle_pkg::run_t    s_run_q;
  logic                s_cen_q;
  bmprle_pkg::result_t s_res, skid_q;

  assign s_res.run           = s_run_q;
  assign s_res.first_colour  = s_cen_q ? rdata_a_i : 32'd0;
  assign s_res.second_colour = s_cen_q ? rdata_b_i : 32'd0;

  assign out_valid_o = skid_v_q || s_v_q;
  assign in_stall_o  = skid_v_q;
  assign res_o       = skid_v_q ? skid_q : s_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_v_q    <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (!out_stall_i) begin
        skid_v_q <= 1'b0;
      end
    end else if (s_v_q && out_stall_i) begin
      // stalled beat moves aside when a new one arrives behind it
      if (load_i) begin
        skid_v_q <= 1'b1;
      end
    end else begin
      s_v_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      s_run_q <= run_i;
      s_cen_q <= cen_i;
    end
    if (!skid_v_q && s_v_q && out_stall_i && load_i) begin
      skid_q <= s_res;
    end
  end

endmodule

`default_nettype wire

/* sv/bmp_rle_palette_decoder.sv */
// Top level of the BMP RLE4/RLE8 palette decoder.
//
//   channel  direction  handshake                 beat
//   in       input      in_valid_i / in_stall_o   kind, palette write or compressed byte
//   out      output     out_valid_o / out_stall_i run descriptor with colours
//   cfg      input      cfg_we_i                  register index and write data
//
// One input beat per cycle while in_stall_o is low; a run is registered in the output
// stage together with the palette memory read that fetches its colours.
// in_stall_o comes from the skid register only, so a new beat is taken while a
// finished run waits; the input stalls once two runs are held.
// Reset clears the control state and the palette valid bits; no clearing pass
// runs over the palette memory.
`default_nettype none

module bmp_rle_palette_decoder #(
  parameter int unsigned PaletteDepth = bmprle_pkg::PaletteDepthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [30:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  in_kind_i,
  input  wire logic [7:0]  in_palette_index_i,
  input  wire logic [31:0] in_palette_colour_i,
  input  wire logic [7:0]  in_data_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [15:0]      out_row_o,
  output logic [16:0]      out_start_column_o,
  output logic [16:0]      out_run_length_o,
  output logic [31:0]      out_first_colour_o,
  output logic [31:0]      out_second_colour_o,
  output logic             out_line_end_o,
  output logic             out_image_end_o,
  output logic [2:0]       out_status_o
);

  logic                accept, emit, cen, pal_we;
  logic [7:0]          raddr_a, raddr_b;
  logic [31:0]         rdata_a, rdata_b;
  bmprle_pkg::run_t    run;
  bmprle_pkg::result_t res;

  assign accept = in_valid_i && !in_stall_o;
  assign pal_we = accept && (in_kind_i == bmprle_pkg::KindPalette);

  bmprle_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .kind_i      (in_kind_i),
    .data_byte_i (in_data_byte_i),
    .emit_o      (emit),
    .cen_o       (cen),
    .run_o       (run),
    .raddr_a_o   (raddr_a),
    .raddr_b_o   (raddr_b)
  );

  bmprle_pal_mem #(
    .PaletteDepth (PaletteDepth)
  ) u_pal_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .we_i      (pal_we),
    .waddr_i   (in_palette_index_i),
    .wdata_i   (in_palette_colour_i),
    .re_i      (emit),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  bmprle_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (emit),
    .cen_i       (cen),
    .run_i       (run),
    .rdata_a_i   (rdata_a),
    .rdata_b_i   (rdata_b),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .in_stall_o  (in_stall_o),
    .res_o       (res)
  );

  assign out_row_o           = res.run.row;
  assign out_start_column_o  = res.run.start_column;
  assign out_run_length_o    = res.run.run_length;
  assign out_first_colour_o  = res.first_colour;
  assign out_second_colour_o = res.second_colour;
  assign out_line_end_o      = res.run.line_end;
  assign out_image_end_o     = res.run.image_end;
  assign out_status_o        = res.run.status;

  // The input only stalls while results are held.
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result held");

  // Error beats carry no pixels, no colours and no end flags.
  a_error_beat_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_status_o != bmprle_pkg::StOk) |->
      (out_run_length_o == 17'd0 && out_first_colour_o == 32'd0
       && out_second_colour_o == 32'd0 && !out_line_end_o && !out_image_end_o))
    else $error("error beat carries run data");

  // A run never closes a row and the image at once.
  a_end_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_line_end_o && out_image_end_o))
    else $error("line end and image end on one beat");

endmodule

`default_nettype wire
